// ----- sv/bntd_pkg.sv -----
// ----------------------------------------------------------------------------
// bntd_pkg
// Shared types and constants for the base-N text decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bntd_pkg;

    // alphabet select
    localparam logic [1:0] MODE_B64   = 2'd0;
    localparam logic [1:0] MODE_B32H  = 2'd1;
    localparam logic [1:0] MODE_B16   = 2'd2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;

    // default depth of the queue between classifier and decoder
    localparam int unsigned Q_DEPTH   = 4;

    typedef enum logic [1:0] {
        CK_SKIP,
        CK_PAD,
        CK_DATA,
        CK_BAD
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_CHAR,
        ST_MID_PAD,
        ST_TOO_MANY_PADS,
        ST_BAD_PAD_COUNT,
        ST_INCOMPLETE,
        ST_PAD_BITS
    } t_status;

    // one classified character as it travels through the queue
    typedef struct packed {
        t_kind      kind;
        logic [5:0] value;
        logic [2:0] bits;
        logic [2:0] max_pads;
        logic       last;
    } t_entry;

endpackage

`default_nettype wire

// ----- sv/bntd_front.sv -----
// ----------------------------------------------------------------------------
// bntd_front
// Character classifier: maps one text byte to skip, pad, data or bad, with
// its alphabet value and the per-character bit width of the current mode.
// ----------------------------------------------------------------------------
`default_nettype none

module bntd_front (
    input  wire logic [1:0]      i_mode,
    input  wire logic [7:0]      i_char_in,
    input  wire logic            i_char_valid,
    input  wire logic            i_last,
    output bntd_pkg::t_entry     o_entry
);

    logic       is_space;
    logic       is_digit;
    logic       hit;
    logic [5:0] value;
    logic [7:0] c;

    assign c        = i_char_in;
    assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    assign is_digit = (c >= "0" && c <= "9");

    always_comb begin
        hit   = 1'b0;
        value = '0;
        unique case (i_mode)
            bntd_pkg::MODE_B64: begin
                if (c >= "A" && c <= "Z") begin
                    hit   = 1'b1;
                    value = 6'(c - "A");
                end else if (c >= "a" && c <= "z") begin
                    hit   = 1'b1;
                    value = 6'(c - "a" + 8'd26);
                end else if (is_digit) begin
                    hit   = 1'b1;
                    value = 6'(c - "0" + 8'd52);
                end else if (c == "+") begin
                    hit   = 1'b1;
                    value = 6'd62;
                end else if (c == "/") begin
                    hit   = 1'b1;
                    value = 6'd63;
                end
            end
            bntd_pkg::MODE_B32H: begin
                if (is_digit) begin
                    hit   = 1'b1;
                    value = 6'(c - "0");
                end else if (c >= "A" && c <= "V") begin
                    hit   = 1'b1;
                    value = 6'(c - "A" + 8'd10);
                end else if (c >= "a" && c <= "v") begin
                    hit   = 1'b1;
                    value = 6'(c - "a" + 8'd10);
                end
            end
            default: begin
                // base16, unused code decodes the same way
                if (is_digit) begin
                    hit   = 1'b1;
                    value = 6'(c - "0");
                end else if (c >= "A" && c <= "F") begin
                    hit   = 1'b1;
                    value = 6'(c - "A" + 8'd10);
                end else if (c >= "a" && c <= "f") begin
                    hit   = 1'b1;
                    value = 6'(c - "a" + 8'd10);
                end
            end
        endcase
    end

    always_comb begin
        o_entry.value = value;
        o_entry.last  = i_last;
        unique case (i_mode)
            bntd_pkg::MODE_B64: begin
                o_entry.bits     = 3'd6;
                o_entry.max_pads = 3'd2;
            end
            bntd_pkg::MODE_B32H: begin
                o_entry.bits     = 3'd5;
                o_entry.max_pads = 3'd6;
            end
            default: begin
                o_entry.bits     = 3'd4;
                o_entry.max_pads = 3'd0;
            end
        endcase
        priority if (!i_char_valid || is_space) begin
            o_entry.kind = bntd_pkg::CK_SKIP;
        end else if (c == bntd_pkg::PAD_CHAR) begin
            o_entry.kind = bntd_pkg::CK_PAD;
        end else if (hit) begin
            o_entry.kind = bntd_pkg::CK_DATA;
        end else begin
            o_entry.kind = bntd_pkg::CK_BAD;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bntd_queue.sv -----
// ----------------------------------------------------------------------------
// bntd_queue
// Small first-in first-out buffer of classified characters between the
// classifier and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module bntd_queue #(
    parameter int unsigned DEPTH = bntd_pkg::Q_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bntd_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output bntd_pkg::t_entry      o_entry
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bntd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bntd_back.sv -----
// ----------------------------------------------------------------------------
// bntd_back
// Decoder: packs alphabet values into bytes, tracks padding and errors,
// runs the end-of-string checks and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bntd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire bntd_pkg::t_entry i_entry,
    output logic                  o_pop,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_byte_valid,
    output logic [7:0]            o_data_byte,
    output logic                  o_done_res,
    output logic [2:0]            o_status
);

    // stream state
    logic [6:0]        r_store;
    logic [2:0]        r_count;
    logic [2:0]        r_total;
    logic [2:0]        r_pads;
    logic              r_in_pad;
    bntd_pkg::t_status r_err;
    logic [6:0]        n_store;
    logic [2:0]        n_count;
    logic [2:0]        n_total;
    logic [2:0]        n_pads;
    logic              n_in_pad;
    bntd_pkg::t_status n_err;

    // result register
    logic              r_out_valid;
    logic              r_byte_valid;
    logic [7:0]        r_data_byte;
    logic              r_done_res;
    bntd_pkg::t_status r_status;
    logic              n_byte_valid;
    logic [7:0]        n_data_byte;
    bntd_pkg::t_status n_status;

    logic [12:0]       acc;
    logic [3:0]        nbits;
    logic [3:0]        nrem;
    logic [6:0]        pad_bits;
    logic [6:0]        pad_room;

    assign o_pop        = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid  = r_out_valid;
    assign o_byte_valid = r_byte_valid;
    assign o_data_byte  = r_data_byte;
    assign o_done_res   = r_done_res;
    assign o_status     = r_status;

    assign acc   = ({6'b0, r_store} << i_entry.bits) | {7'b0, i_entry.value};
    assign nbits = {1'b0, r_count} + {1'b0, i_entry.bits};
    assign nrem  = (nbits >= 4'd8) ? nbits - 4'd8 : nbits;

    always_comb begin
        n_store      = r_store;
        n_count      = r_count;
        n_total      = r_total;
        n_pads       = r_pads;
        n_in_pad     = r_in_pad;
        n_err        = r_err;
        n_byte_valid = 1'b0;
        n_data_byte  = '0;
        if (r_err == bntd_pkg::ST_OK) begin
            unique case (i_entry.kind)
                bntd_pkg::CK_SKIP: begin
                end
                bntd_pkg::CK_PAD: begin
                    n_in_pad = 1'b1;
                    n_pads   = (r_pads != 3'd7) ? r_pads + 3'd1 : r_pads;
                    n_total  = r_total + i_entry.bits;
                    if (n_pads > i_entry.max_pads) begin
                        n_err = bntd_pkg::ST_TOO_MANY_PADS;
                    end
                end
                bntd_pkg::CK_DATA: begin
                    if (r_in_pad) begin
                        n_err = bntd_pkg::ST_MID_PAD;
                    end else begin
                        if (nbits >= 4'd8) begin
                            n_byte_valid = 1'b1;
                            n_data_byte  = 8'(acc >> nrem);
                        end
                        n_store = 7'(acc & ((13'd1 << nrem) - 13'd1));
                        n_count = 3'(nrem);
                        n_total = r_total + i_entry.bits;
                    end
                end
                bntd_pkg::CK_BAD: begin
                    n_err = r_in_pad ? bntd_pkg::ST_MID_PAD : bntd_pkg::ST_BAD_CHAR;
                end
            endcase
        end
    end

    // end checks on the state after this transaction
    assign pad_bits = (7'({4'b0, n_pads} * {4'b0, i_entry.bits}) + 7'd7) & 7'b1111000;
    assign pad_room = 7'(({4'b0, n_pads} + 7'd1) * {4'b0, i_entry.bits});

    always_comb begin
        n_status = bntd_pkg::ST_OK;
        if (i_entry.last) begin
            priority if (n_err != bntd_pkg::ST_OK) begin
                n_status = n_err;
            end else if (pad_bits > pad_room) begin
                n_status = bntd_pkg::ST_BAD_PAD_COUNT;
            end else if (n_total != 3'd0) begin
                n_status = bntd_pkg::ST_INCOMPLETE;
            end else if (n_pads != 3'd0 && n_store != 7'd0) begin
                n_status = bntd_pkg::ST_PAD_BITS;
            end else begin
                n_status = bntd_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store     <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_pads      <= '0;
            r_in_pad    <= 1'b0;
            r_err       <= bntd_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_entry.last) begin
                    r_store  <= '0;
                    r_count  <= '0;
                    r_total  <= '0;
                    r_pads   <= '0;
                    r_in_pad <= 1'b0;
                    r_err    <= bntd_pkg::ST_OK;
                end else begin
                    r_store  <= n_store;
                    r_count  <= n_count;
                    r_total  <= n_total;
                    r_pads   <= n_pads;
                    r_in_pad <= n_in_pad;
                    r_err    <= n_err;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte_valid <= n_byte_valid;
            r_data_byte  <= n_data_byte;
            r_done_res   <= i_entry.last;
            r_status     <= n_status;
        end
    end

endmodule

`default_nettype wire

// ----- sv/base_n_text_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base_n_text_decoder_unit
// Streaming base64 / base32hex / base16 text decoder, one character per
// transaction, one result per character.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  -----------------------------------
//  in        sink       i_in_valid/o_in_stall i_char_in, i_char_valid, i_last
//  out       source     o_out_valid/i_out_stall o_byte_valid, o_data_byte,
//                                             o_done_res, o_status
//  cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_mode
//
//  one character per cycle sustained while i_out_stall is low; a taken
//  character passes the queue write, then the decoder's result register
//  the rate is set by the combinational bit packing step in the decoder
//  synchronous active-low reset clears the queue, stream state and mode
//  (base64); o_in_stall rises only when the queue is full, so a stall on
//  the output side reaches the input after the queue depth
// ----------------------------------------------------------------------------
`default_nettype none

module base_n_text_decoder_unit #(
    parameter int unsigned Q_DEPTH = bntd_pkg::Q_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input characters
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_char_valid,
    input  wire logic        i_last,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_byte_valid,
    output logic [7:0]       o_data_byte,
    output logic             o_done_res,
    output logic [2:0]       o_status,
    // mode register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_mode
);

    logic [1:0]        r_mode;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              q_push;
    bntd_pkg::t_entry  front_entry;
    bntd_pkg::t_entry  q_entry;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign q_push      = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bntd_pkg::MODE_B64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_mode;
        end
    end

    bntd_front u_front (
        .i_mode       (r_mode),
        .i_char_in    (i_char_in),
        .i_char_valid (i_char_valid),
        .i_last       (i_last),
        .o_entry      (front_entry)
    );

    bntd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    bntd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_entry      (q_entry),
        .o_pop        (q_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_byte_valid (o_byte_valid),
        .o_data_byte  (o_data_byte),
        .o_done_res   (o_done_res),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base64 / base32hex / base16 text decoder: a
// directed table of corner cases, then random encoded strings in every
// alphabet, good and broken, with random idling on both channels. Results are
// checked field by field against table values or a cycle-free decode model.
// ----------------------------------------------------------------------------
module tb;
    import bntd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned N_PHASES       = 10;
    localparam int unsigned PHASE_CHARS    = 155;
    localparam int unsigned N_DIR          = 29;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       lst;
    } char_t;

    typedef struct packed {
        logic       bv;
        logic [7:0] db;
        logic       done;
        t_status    st;
    } res_t;

    typedef enum logic {
        ROW_CHAR,
        ROW_MODE
    } row_kind_e;

    typedef struct {
        row_kind_e  kind;
        logic [1:0] mode;
        logic [7:0] ch;
        logic       cv;
        logic       lst;
        logic       pin;
        logic       pbv;
        logic [7:0] pdb;
        t_status    pst;
    } row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_char_in;
    logic       i_char_valid;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_byte_valid;
    logic [7:0] o_data_byte;
    logic       o_done_res;
    logic [2:0] o_status;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_mode;

    // decode model state
    logic [1:0] dec_mode;
    logic [6:0] dec_store;
    logic [2:0] dec_nbits;
    logic [2:0] dec_mod8;
    logic [2:0] dec_pads;
    logic       dec_in_pad;
    t_status    dec_err;

    res_t        decoded_q [$];
    char_t       text_q [$];
    row_t        dir_tab [N_DIR];
    res_t        want;
    bit          idle_on;
    int unsigned stall_left;
    int unsigned quiet;
    int unsigned n_err;
    int unsigned n_items;
    int unsigned n_texts;
    int unsigned n_cfg;
    int unsigned n_checked;

    base_n_text_decoder_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_in    (i_char_in),
        .i_char_valid (i_char_valid),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_byte_valid (o_byte_valid),
        .o_data_byte  (o_data_byte),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_mode   (i_cfg_mode)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned bits_per_char(input logic [1:0] m);
        case (m)
            MODE_B64:  return 6;
            MODE_B32H: return 5;
            default:   return 4;
        endcase
    endfunction

    function automatic int unsigned pad_limit(input logic [1:0] m);
        case (m)
            MODE_B64:  return 2;
            MODE_B32H: return 6;
            default:   return 0;
        endcase
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] blank_char();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(8'h09 + k);
    endfunction

    // alphabet value, -1 when the character is not in the alphabet
    function automatic int symbol_value(input logic [7:0] c, input logic [1:0] m);
        if (m == MODE_B64) begin
            if (c >= "A" && c <= "Z") return int'(c) - 65;
            if (c >= "a" && c <= "z") return int'(c) - 97 + 26;
            if (c >= "0" && c <= "9") return int'(c) - 48 + 52;
            if (c == "+") return 62;
            if (c == "/") return 63;
            return -1;
        end
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (m == MODE_B32H) begin
            if (c >= "A" && c <= "V") return int'(c) - 65 + 10;
            if (c >= "a" && c <= "v") return int'(c) - 97 + 10;
            return -1;
        end
        if (c >= "A" && c <= "F") return int'(c) - 65 + 10;
        if (c >= "a" && c <= "f") return int'(c) - 97 + 10;
        return -1;
    endfunction

    // encoder side, letters of the hex alphabets in random case
    function automatic logic [7:0] symbol_char(input int unsigned v, input logic [1:0] m);
        logic lower;
        lower = 1'($urandom_range(0, 1));
        if (m == MODE_B64) begin
            if (v < 26) return 8'(65 + v);
            if (v < 52) return 8'(97 + v - 26);
            if (v < 62) return 8'(48 + v - 52);
            return (v == 62) ? 8'h2B : 8'h2F;
        end
        if (v < 10) return 8'(48 + v);
        return 8'((lower ? 97 : 65) + v - 10);
    endfunction

    function automatic void clear_text_state();
        dec_store  = '0;
        dec_nbits  = '0;
        dec_mod8   = '0;
        dec_pads   = '0;
        dec_in_pad = 1'b0;
        dec_err    = ST_OK;
    endfunction

    function automatic res_t decode_char(input char_t c);
        res_t        r;
        int          v;
        int unsigned b;
        int unsigned acc;
        int unsigned n;
        int unsigned pb;
        b      = bits_per_char(dec_mode);
        r.bv   = 1'b0;
        r.db   = 8'h00;
        r.done = c.lst;
        r.st   = ST_OK;
        if (c.cv && dec_err == ST_OK && !is_blank(c.ch)) begin
            if (c.ch == PAD_CHAR) begin
                dec_in_pad = 1'b1;
                if (dec_pads != 3'd7) dec_pads = dec_pads + 3'd1;
                dec_mod8 = 3'(dec_mod8 + b);
                if (dec_pads > pad_limit(dec_mode)) dec_err = ST_TOO_MANY_PADS;
            end else if (dec_in_pad) begin
                dec_err = ST_MID_PAD;
            end else begin
                v = symbol_value(c.ch, dec_mode);
                if (v < 0) begin
                    dec_err = ST_BAD_CHAR;
                end else begin
                    acc = (32'(dec_store) << b) | 32'(v);
                    n   = dec_nbits + b;
                    if (n >= 8) begin
                        n    = n - 8;
                        r.bv = 1'b1;
                        r.db = 8'(acc >> n);
                    end
                    dec_store = 7'(acc & ((32'd1 << n) - 1));
                    dec_nbits = 3'(n);
                    dec_mod8  = 3'(dec_mod8 + b);
                end
            end
        end
        if (c.lst) begin
            r.st = dec_err;
            if (dec_err == ST_OK) begin
                pb = (dec_pads * b + 7) & ~32'd7;
                if (pb > b * (dec_pads + 1))
                    r.st = ST_BAD_PAD_COUNT;
                else if (dec_mod8 != 0)
                    r.st = ST_INCOMPLETE;
                else if (dec_pads != 0 && dec_store != 0)
                    r.st = ST_PAD_BITS;
            end
            clear_text_state();
        end
        return r;
    endfunction

    // one random encoded string in the current alphabet, good or broken
    task automatic make_text();
        logic [7:0]  raw [24];
        char_t       body [$];
        int unsigned b;
        int unsigned nbytes;
        int unsigned nch;
        int unsigned npad;
        int unsigned kind;
        int unsigned k;
        int unsigned j;
        int unsigned bp;
        int unsigned v;
        int unsigned last_v;
        int unsigned ending;
        logic [7:0]  junk;
        text_q.delete();
        b      = bits_per_char(dec_mode);
        nbytes = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
        for (k = 0; k < nbytes; k++) raw[k] = 8'($urandom);
        nch = (nbytes * 8 + b - 1) / b;
        case (dec_mode)
            MODE_B64:  npad = (4 - nch % 4) % 4;
            MODE_B32H: npad = (8 - nch % 8) % 8;
            default:   npad = 0;
        endcase
        kind   = $urandom_range(0, 99);
        last_v = 0;
        if (kind < 6) begin
            // noise: arbitrary bytes with pads mixed in
            repeat ($urandom_range(1, 6)) begin
                junk = ($urandom_range(0, 3) == 0) ? PAD_CHAR : 8'($urandom);
                body.push_back('{junk, 1'b1, 1'b0});
            end
        end else begin
            for (k = 0; k < nch; k++) begin
                v = 0;
                for (j = 0; j < b; j++) begin
                    bp = k * b + j;
                    v  = (v << 1) | ((bp < nbytes * 8) ? raw[bp / 8][7 - bp % 8] : 1'b0);
                end
                last_v = v;
                body.push_back('{symbol_char(v, dec_mode), 1'b1, 1'b0});
            end
            if (kind < 14)
                npad = 0;
            else if (kind < 22 && nch > 0)
                body[$urandom_range(0, nch - 1)].ch = 8'($urandom);
            else if (kind < 28)
                npad = npad + 1;
            else if (kind < 34 && nch > 0)
                body[nch - 1].ch = symbol_char(last_v ^ 1, dec_mode);
            repeat (npad) body.push_back('{PAD_CHAR, 1'b1, 1'b0});
            // data after the padding
            if (kind >= 34 && kind < 40) begin
                v = $urandom_range(0, (1 << b) - 1);
                body.push_back('{symbol_char(v, dec_mode), 1'b1, 1'b0});
            end
        end
        foreach (body[i]) begin
            if ($urandom_range(0, 9) == 0) text_q.push_back('{blank_char(), 1'b1, 1'b0});
            if ($urandom_range(0, 39) == 0) text_q.push_back('{8'($urandom), 1'b0, 1'b0});
            text_q.push_back(body[i]);
        end
        ending = $urandom_range(0, 7);
        if (text_q.size() == 0 || ending < 2)
            text_q.push_back('{8'($urandom), 1'b0, 1'b1});
        else if (ending == 2)
            text_q.push_back('{blank_char(), 1'b1, 1'b1});
        else
            text_q[text_q.size() - 1].lst = 1'b1;
    endtask

    task automatic push_char(input char_t c, input logic pin, input logic pbv,
                             input logic [7:0] pdb, input t_status pst);
        res_t got;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_char_in    <= c.ch;
        i_char_valid <= c.cv;
        i_last       <= c.lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = decode_char(c);
        if (pin)
            decoded_q.push_back('{pbv, pdb, c.lst, pst});
        else
            decoded_q.push_back(got);
        n_items++;
    endtask

    // mode changes only with the decoder drained
    task automatic write_mode(input logic [1:0] m);
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_mode  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        dec_mode = m;
        n_cfg++;
    endtask

    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want_v,
                     got_v);
            n_err++;
        end
    endtask

    // result side: check each transaction, stall in short bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0b/%0h/%0b/%0d",
                             $time, o_byte_valid, o_data_byte, o_done_res, o_status);
                    n_err++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("byte_valid", 8'(want.bv), 8'(o_byte_valid));
                    check_field("data_byte", want.db, o_data_byte);
                    check_field("done_res", 8'(want.done), 8'(o_done_res));
                    check_field("status", 8'(want.st), 8'(o_status));
                    n_checked++;
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, quiet);
                $display("[base_n_text_decoder_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned ph;
        int unsigned sent;
        logic [1:0]  m;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_char_in    <= 8'h00;
        i_char_valid <= 1'b0;
        i_last       <= 1'b0;
        i_out_stall  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_mode   <= MODE_B64;
        idle_on   = 1'b1;
        quiet     = 0;
        n_err     = 0;
        n_items   = 0;
        n_texts   = 0;
        n_cfg     = 0;
        n_checked = 0;
        dec_mode  = MODE_B64;
        clear_text_state();

        dir_tab = '{
            '{ROW_MODE, MODE_B64, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            // empty string
            '{ROW_CHAR, MODE_B64, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "T",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "W",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "F",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "u",   1'b1, 1'b1, 1'b1, 1'b1, 8'h6E, ST_OK},
            // whitespace inside, leftover bit under padding
            '{ROW_CHAR, MODE_B64, "Q",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, 8'h20, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "R",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, 8'h0D, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_PAD_BITS},
            '{ROW_CHAR, MODE_B64, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_BAD_CHAR},
            // error latched, later data ignored
            '{ROW_CHAR, MODE_B64, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "A",   1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_BAD_CHAR},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "A",   1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_MID_PAD},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_TOO_MANY_PADS},
            '{ROW_CHAR, MODE_B64, "A",   1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_INCOMPLETE},
            '{ROW_MODE, MODE_B32H, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "v",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "0",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_BAD_PAD_COUNT},
            '{ROW_MODE, MODE_B16, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            // base16 allows no padding at all
            '{ROW_CHAR, MODE_B64, "f",   1'b1, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
            '{ROW_CHAR, MODE_B64, "=",   1'b1, 1'b1, 1'b1, 1'b0, 8'h00, ST_TOO_MANY_PADS}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_MODE)
                write_mode(dir_tab[i].mode);
            else
                push_char('{dir_tab[i].ch, dir_tab[i].cv, dir_tab[i].lst}, dir_tab[i].pin,
                          dir_tab[i].pbv, dir_tab[i].pdb, dir_tab[i].pst);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            idle_on = (ph != 4) && (ph != N_PHASES - 1);
            case (ph)
                0:       m = MODE_B64;
                1:       m = MODE_B32H;
                2:       m = MODE_B16;
                default: m = 2'($urandom_range(0, 2));
            endcase
            write_mode(m);
            sent = 0;
            while (sent < PHASE_CHARS) begin
                make_text();
                foreach (text_q[i]) begin
                    push_char(text_q[i], 1'b0, 1'b0, 8'h00, ST_OK);
                    if (!(text_q[i].cv && is_blank(text_q[i].ch))) sent++;
                end
                n_texts++;
            end
        end
        i_in_valid <= 1'b0;

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("fed %0d characters (%0d random strings) over %0d mode writes", n_items,
                 n_texts, n_cfg);
        $display("checked %0d results in all three alphabets, %0d mismatches", n_checked,
                 n_err);
        if (n_err == 0)
            $display("[base_n_text_decoder_unit] OK");
        else
            $display("[base_n_text_decoder_unit] ERROR");
        $finish;
    end

endmodule

// ----- base_n_text_decoder_unit.f -----
sv/bntd_pkg.sv
sv/bntd_front.sv
sv/bntd_queue.sv
sv/bntd_back.sv
sv/base_n_text_decoder_unit.sv
tb/sv/tb.sv
